// ===== hw/rtl/iols_pkg.sv =====
// Shared types and constants for the indexed ordered list store.
// No dependencies; imported by iols_cell and indexed_ordered_list_store_unit.
`default_nettype none

package iols_pkg;

  // Payload widths fixed by the interface
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell of the chain; at most one flag is set
  typedef struct packed {
    logic wr_ins;    // open a slot at pos, later entries move up
    logic wr_del;    // close the slot at pos, later entries move down
    logic wr_app;    // write data into the slot at fill
    logic rd_load;   // copy entries into the read-out chain
    logic rd_shift;  // move the read-out chain one cell toward cell 0
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iols_cell.sv =====
// One cell of the list chain: holds a single entry and one read-out stage.
// Depends on iols_pkg; instantiated in a row by indexed_ordered_list_store_unit.
`default_nettype none

module iols_cell #(
  parameter int unsigned CELL_INDEX = 0,
  parameter int unsigned POS_W      = 7
) (
  input  logic                       clk,
  input  iols_pkg::cell_ctl_t        ctl,
  input  logic [POS_W-1:0]           pos,
  input  logic [POS_W-1:0]           fill,
  input  logic [iols_pkg::DATA_W-1:0] data,
  input  logic [iols_pkg::DATA_W-1:0] left_entry,
  input  logic [iols_pkg::DATA_W-1:0] right_entry,
  input  logic [iols_pkg::DATA_W-1:0] right_carry,
  output logic [iols_pkg::DATA_W-1:0] entry,
  output logic [iols_pkg::DATA_W-1:0] carry
);
  import iols_pkg::*;

  localparam logic [POS_W-1:0] IDX = POS_W'(CELL_INDEX);

  logic [DATA_W-1:0] entry_next;
  logic [DATA_W-1:0] carry_next;

  // Entry update: take from a neighbor or from the input beat
  always_comb begin
    entry_next = entry;
    priority if (ctl.wr_ins) begin
      if (pos < IDX) begin
        entry_next = left_entry;
      end else if (pos == IDX) begin
        entry_next = data;
      end
    end else if (ctl.wr_del) begin
      if (pos <= IDX) begin
        entry_next = right_entry;
      end
    end else if (ctl.wr_app) begin
      if (fill == IDX) begin
        entry_next = data;
      end
    end
  end

  // Read-out stage: load a copy, then shift toward cell 0
  always_comb begin
    carry_next = carry;
    priority if (ctl.rd_load) begin
      carry_next = entry;
    end else if (ctl.rd_shift) begin
      carry_next = right_carry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    carry <= carry_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_ordered_list_store_unit.sv =====
// Indexed ordered list store: a row of DEPTH cells holding a packed list.
// Rate: append, insert and delete take one cycle each, so start may be taken
// on every cycle and each result strobes done in the cycle after its accept.
// A successful read keeps busy high while the entries, copied into a read-out
// chain, move one cell per cycle toward cell 0; done strobes in the cycle in
// which busy falls. A failed read strobes done in the cycle after its accept.
// Each result is on status, read_value and entry_count for exactly one cycle
// with done high; the receiver cannot stall. Depends on iols_pkg, iols_cell.
`default_nettype none

module indexed_ordered_list_store_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [iols_pkg::OP_W-1:0]         operation,
  input  logic [$clog2(DEPTH+1)-1:0]        position,
  input  logic signed [iols_pkg::DATA_W-1:0] data_value,
  output logic                              busy,
  output logic                              done,
  output logic [iols_pkg::STATUS_W-1:0]     status,
  output logic signed [iols_pkg::DATA_W-1:0] read_value,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count
);
  import iols_pkg::*;

  localparam int unsigned POS_W = $clog2(DEPTH + 1);
  localparam logic [POS_W-1:0] FULL_COUNT = POS_W'(DEPTH);

  // FSM codes
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic             state, state_next;
  logic [POS_W-1:0] count, count_next;
  logic [POS_W-1:0] rem, rem_next;
  logic             accept;
  cell_ctl_t        ctl;

  logic                    done_next;
  logic [STATUS_W-1:0]     status_next;
  logic [DATA_W-1:0]       read_value_next;

  logic [DATA_W-1:0] cell_entry [DEPTH];
  logic [DATA_W-1:0] cell_carry [DEPTH];
  logic [DATA_W-1:0] left_in    [DEPTH];
  logic [DATA_W-1:0] right_in   [DEPTH];
  logic [DATA_W-1:0] rcarry_in  [DEPTH];

  assign busy   = (state == S_READ);
  assign accept = start && !busy;

  // Command decode and sequencing
  always_comb begin
    state_next      = state;
    count_next      = count;
    rem_next        = rem;
    ctl             = '0;
    done_next       = 1'b0;
    status_next     = ST_DONE;
    read_value_next = '0;
    if (state == S_READ) begin
      if (rem == '0) begin
        done_next       = 1'b1;
        read_value_next = cell_carry[0];
        state_next      = S_IDLE;
      end else begin
        ctl.rd_shift = 1'b1;
        rem_next     = rem - 1'b1;
      end
    end else if (accept) begin
      unique case (operation)
        OP_APPEND: begin
          done_next = 1'b1;
          if (count == FULL_COUNT) begin
            status_next = ST_FULL;
          end else begin
            ctl.wr_app = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_INSERT: begin
          done_next = 1'b1;
          priority if (position > count) begin
            status_next = ST_RANGE;
          end else if (count == FULL_COUNT) begin
            status_next = ST_FULL;
          end else begin
            ctl.wr_ins = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_DELETE: begin
          done_next = 1'b1;
          if (position >= count) begin
            status_next = ST_RANGE;
          end else begin
            ctl.wr_del = 1'b1;
            count_next = count - 1'b1;
          end
        end
        OP_READ: begin
          if (position >= count) begin
            done_next       = 1'b1;
            status_next     = ST_RANGE;
            read_value_next = '1;
          end else begin
            ctl.rd_load = 1'b1;
            rem_next    = position;
            state_next  = S_READ;
          end
        end
        default: begin
          done_next = 1'b0;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Result and counter payload
  always_ff @(posedge clk) begin
    rem <= rem_next;
    if (done_next) begin
      status      <= status_next;
      read_value  <= read_value_next;
      entry_count <= count_next;
    end
  end

  // Cell chain with neighbor links; the ends see zeros
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '0;
    end else begin : g_left
      assign left_in[i] = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in[i]  = '0;
      assign rcarry_in[i] = '0;
    end else begin : g_right
      assign right_in[i]  = cell_entry[i+1];
      assign rcarry_in[i] = cell_carry[i+1];
    end

    iols_cell #(
      .CELL_INDEX(i),
      .POS_W     (POS_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (position),
      .fill       (count),
      .data       (data_value),
      .left_entry (left_in[i]),
      .right_entry(right_in[i]),
      .right_carry(rcarry_in[i]),
      .entry      (cell_entry[i]),
      .carry      (cell_carry[i])
    );
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above depth");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl))
    else $error("more than one cell command at once");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while read still running");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < count))
    else $error("read-out countdown beyond list end");

  a_count_stable_read: assert property (@(posedge clk) disable iff (rst)
    busy |=> (count == $past(count)))
    else $error("list changed during read-out");

endmodule

`default_nettype wire

// ===== verif/indexed_ordered_list_store_unit_tb.sv =====
// Self-checking testbench for the indexed ordered list store: directed and random command beats.
// A shadow list predicts every reply, and a scoreboard compares each one field by field.
// Depends on iols_pkg and indexed_ordered_list_store_unit.
`timescale 1ns / 100ps

module indexed_ordered_list_store_unit_tb;
  import iols_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned CW          = $clog2(DEPTH + 1);
  localparam int          RANDOM_CMDS = 1950;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          REPORT_CAP  = 40;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [CW-1:0]            pos;
    logic signed [DATA_W-1:0] val;
    int                       gap;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [CW-1:0]            entry_count;
  } reply_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [OP_W-1:0]          operation = OP_APPEND;
  logic [CW-1:0]            position = '0;
  logic signed [DATA_W-1:0] data_value = '0;
  logic                     busy;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] read_value;
  logic [CW-1:0]            entry_count;

  cmd_t   pending_cmds[$];
  reply_t expected_replies[$];

  // shadow of the list held by the block
  logic signed [DATA_W-1:0] held_list [DEPTH];
  int held_count = 0;
  int peak_count = 0;

  // fill level as seen by the stimulus generator
  int gen_fill = 0;
  bit calm_phase = 1'b0;

  int  items_total = 0;
  int  beats_accepted = 0;
  int  replies_seen = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  op_seen [4];
  int  status_seen [4];
  bit  beat_taken = 1'b0;
  bit  driving = 1'b0;
  int  gap_left = 0;
  int  cur_gap = 0;

  indexed_ordered_list_store_unit #(.DEPTH(DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .position    (position),
    .data_value  (data_value),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the shadow list and return the reply it should produce
  function automatic reply_t apply_list_op(logic [OP_W-1:0] op, logic [CW-1:0] pos,
                                           logic signed [DATA_W-1:0] val);
    reply_t r;
    int p;
    p = int'(pos);
    r.status = ST_DONE;
    r.read_value = '0;
    case (op)
      OP_APPEND: begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_list[held_count] = val;
          held_count++;
        end
      end
      OP_INSERT: begin
        // range check wins over full check
        if (p > held_count) begin
          r.status = ST_RANGE;
        end else if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held_count; i > p; i--) held_list[i] = held_list[i-1];
          held_list[p] = val;
          held_count++;
        end
      end
      OP_DELETE: begin
        if (p >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i < held_count - 1; i++) held_list[i] = held_list[i+1];
          held_count--;
        end
      end
      default: begin
        // read
        if (p >= held_count) begin
          r.status = ST_RANGE;
          r.read_value = '1;
        end else begin
          r.read_value = held_list[p];
        end
      end
    endcase
    if (held_count > peak_count) peak_count = held_count;
    r.entry_count = held_count[CW-1:0];
    return r;
  endfunction

  // Gap after a beat: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_phase) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Position around an in-range upper bound; sometimes just past it or anywhere
  function automatic logic [CW-1:0] pick_pos(int top);
    int roll;
    roll = $urandom_range(0, 99);
    if (top < 0) return (roll < 50) ? '0 : CW'($urandom_range(0, DEPTH));
    if (roll < 65) return CW'($urandom_range(0, top));
    if (roll < 75) return '0;
    if (roll < 85) return CW'(top);
    if (roll < 92 && top < DEPTH) return CW'(top + 1);
    return CW'($urandom_range(0, DEPTH));
  endfunction

  // Queue a command and track the fill level it leaves behind
  task automatic add_cmd(logic [OP_W-1:0] op, logic [CW-1:0] pos, logic signed [DATA_W-1:0] val);
    cmd_t c;
    c.op = op;
    c.pos = pos;
    c.val = val;
    c.gap = pick_gap();
    pending_cmds.push_back(c);
    case (op)
      OP_APPEND: if (gen_fill < DEPTH) gen_fill++;
      OP_INSERT: if (int'(pos) <= gen_fill && gen_fill < DEPTH) gen_fill++;
      OP_DELETE: if (int'(pos) < gen_fill) gen_fill--;
      default: ;
    endcase
  endtask

  task automatic add_rand_read();
    add_cmd(OP_READ, pick_pos(gen_fill - 1), pick_value());
  endtask

  task automatic build_directed();
    add_cmd(OP_READ,   7'd0,  '0);               // read on empty list
    add_cmd(OP_DELETE, 7'd0,  '0);               // delete on empty list
    add_cmd(OP_INSERT, 7'd1,  32'sd5);           // insert past the end
    add_cmd(OP_INSERT, 7'd0,  32'sh7FFF_FFFF);   // head insert into empty list
    add_cmd(OP_APPEND, 7'd0,  32'sh8000_0000);
    add_cmd(OP_INSERT, 7'd0,  '1);               // head insert, everything shifts up
    add_cmd(OP_INSERT, 7'd3,  '0);               // position equal to count appends
    add_cmd(OP_INSERT, 7'd2,  32'sh1234_5678);   // middle insert
    add_cmd(OP_READ,   7'd0,  '0);
    add_cmd(OP_READ,   7'd4,  '0);               // last entry
    add_cmd(OP_READ,   7'd5,  '0);               // one past the end
    add_cmd(OP_READ,   7'd64, '0);
    add_cmd(OP_DELETE, 7'd0,  '0);               // head delete
    add_cmd(OP_READ,   7'd0,  '0);
    add_cmd(OP_DELETE, 7'd3,  '0);               // tail delete
    add_cmd(OP_READ,   7'd3,  '0);
    add_cmd(OP_DELETE, 7'd1,  '0);               // middle delete
    add_cmd(OP_READ,   7'd1,  '0);
    add_cmd(OP_APPEND, 7'd64, 32'sh5555_5555);   // append ignores position
    add_cmd(OP_APPEND, 7'd63, 32'shAAAA_AAAA);
    add_cmd(OP_INSERT, 7'd64, 32'sd9);
    add_cmd(OP_DELETE, 7'd64, '0);
    add_cmd(OP_READ,   7'd3,  '0);
  endtask

  // One random phase; returns the number of beats it queued
  task automatic build_phase(output int added);
    int kind;
    int len;
    int start_size;
    start_size = pending_cmds.size();
    kind = $urandom_range(0, 9);
    calm_phase = ($urandom_range(0, 4) == 0);
    if (kind < 3) begin
      // fill to full, then hit the full list
      while (gen_fill < DEPTH) begin
        case ($urandom_range(0, 7))
          0, 1: add_rand_read();
          2, 3, 4: add_cmd(OP_APPEND, CW'($urandom_range(0, DEPTH)), pick_value());
          5: add_cmd(OP_DELETE, pick_pos(gen_fill - 1), '0);
          default: add_cmd(OP_INSERT, pick_pos(gen_fill), pick_value());
        endcase
      end
      len = $urandom_range(2, 5);
      repeat (len) begin
        case ($urandom_range(0, 2))
          0: add_cmd(OP_APPEND, CW'($urandom_range(0, DEPTH)), pick_value());
          1: add_cmd(OP_INSERT, CW'($urandom_range(0, DEPTH)), pick_value());
          default: add_rand_read();
        endcase
      end
    end else if (kind < 5) begin
      // drain to empty, then poke the empty list
      while (gen_fill > 0) begin
        case ($urandom_range(0, 7))
          0, 1: add_rand_read();
          2: add_cmd(OP_INSERT, pick_pos(gen_fill), pick_value());
          default: add_cmd(OP_DELETE, pick_pos(gen_fill - 1), '0);
        endcase
      end
      len = $urandom_range(1, 3);
      repeat (len) begin
        if ($urandom_range(0, 1) == 0) add_cmd(OP_DELETE, pick_pos(-1), '0);
        else add_cmd(OP_READ, pick_pos(-1), '0);
      end
    end else if (kind < 9) begin
      // mixed traffic around the current fill level
      len = $urandom_range(20, 60);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0: add_cmd(OP_APPEND, CW'($urandom_range(0, DEPTH)), pick_value());
          1: add_cmd(OP_INSERT, pick_pos(gen_fill), pick_value());
          2: add_cmd(OP_DELETE, pick_pos(gen_fill - 1), pick_value());
          default: add_rand_read();
        endcase
      end
    end else begin
      // noise: any operation, any position
      len = $urandom_range(10, 30);
      repeat (len) begin
        add_cmd(OP_W'($urandom_range(0, 3)), CW'($urandom_range(0, DEPTH)), pick_value());
      end
    end
    added = pending_cmds.size() - start_size;
  endtask

  // Driver: present the next beat at the falling edge, hold it until taken
  always @(negedge clk) begin
    cmd_t nxt;
    if (rst) begin
      driving = 1'b0;
      start <= 1'b0;
    end else begin
      if (beat_taken) begin
        beat_taken = 1'b0;
        driving = 1'b0;
        gap_left = cur_gap;
      end
      if (!driving) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          driving = 1'b1;
          cur_gap = nxt.gap;
          operation <= nxt.op;
          position <= nxt.pos;
          data_value <= nxt.val;
        end
      end
      start <= driving;
    end
  end

  // Monitor and scoreboard: check replies, then predict the beat taken at this edge
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst) begin
      if (done) begin
        got.status = status;
        got.read_value = read_value;
        got.entry_count = entry_count;
        replies_seen++;
        if (status < 3) status_seen[status]++;
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t ns: reply with no command waiting: status %0d value %0d count %0d",
                     $time, got.status, got.read_value, got.entry_count);
        end else begin
          want = expected_replies.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= REPORT_CAP) begin
              if (got.status != want.status)
                $display("%0t ns: status expected %0d actual %0d",
                         $time, want.status, got.status);
              if (got.read_value != want.read_value)
                $display("%0t ns: read_value expected %0d actual %0d",
                         $time, want.read_value, got.read_value);
              if (got.entry_count != want.entry_count)
                $display("%0t ns: entry_count expected %0d actual %0d",
                         $time, want.entry_count, got.entry_count);
            end
          end
        end
      end
      if (start && !busy) begin
        expected_replies.push_back(apply_list_op(operation, position, data_value));
        op_seen[operation]++;
        beats_accepted++;
        beat_taken = 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached, %0d of %0d beats taken, %0d replies outstanding",
               $time, beats_accepted, items_total, expected_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int random_cmds;
    int added;
    random_cmds = 0;
    build_directed();
    while (random_cmds < RANDOM_CMDS) begin
      build_phase(added);
      random_cmds += added;
    end
    items_total = pending_cmds.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (beats_accepted == items_total);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d beats: %0d append, %0d insert, %0d delete, %0d read; peak fill %0d",
             beats_accepted, op_seen[OP_APPEND], op_seen[OP_INSERT], op_seen[OP_DELETE],
             op_seen[OP_READ], peak_count);
    $display("Replies: %0d done, %0d out of range, %0d full, %0d failures",
             status_seen[ST_DONE], status_seen[ST_RANGE], status_seen[ST_FULL], fail_count);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
